// ===== hw/rtl/dvf_pkg.sv =====
// Shared constants, payload types, controller states and command/status types.
package dvf_pkg;

    localparam int TABLE_DEPTH = 128;
    localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int VALUE_W     = 32;
    localparam int SLOT_W      = 7;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      last_of_set;
    } dvf_in_t;

    typedef struct packed {
        logic                      is_new;
        logic signed [VALUE_W-1:0] value_out;
        logic [SLOT_W-1:0]         slot;
        logic                      overflow;
        logic                      set_done;
    } dvf_out_t;

    typedef enum logic {
        ST_IDLE,
        ST_SEARCH
    } dvf_state_t;

    typedef struct packed {
        logic load;
        logic step;
        logic finish;
    } dvf_cmd_t;

    typedef struct packed {
        logic match;
        logic more;
        logic out_free;
    } dvf_status_t;

endpackage

// ===== hw/rtl/dvf_ctrl.sv =====
// Controller state machine: sequences load, table search steps and result finish.
module dvf_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  dvf_pkg::dvf_status_t status,
    output dvf_pkg::dvf_cmd_t    cmd
);
    import dvf_pkg::*;

    dvf_state_t state_reg;
    dvf_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                if ((status.match || !status.more) && status.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready    = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            ST_SEARCH: begin
                // Hold the search result until the output register frees up.
                if (status.match || !status.more) begin
                    cmd.finish = status.out_free;
                end else begin
                    cmd.step = 1'b1;
                end
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

endmodule

// ===== hw/rtl/dvf_datapath.sv =====
// Datapath: item register, distinct table memory, search index, count and result register.
module dvf_datapath (
    input  logic                aclk,
    input  logic                aresetn,
    input  dvf_pkg::dvf_in_t     s_data,
    input  dvf_pkg::dvf_cmd_t    cmd,
    output dvf_pkg::dvf_status_t status,
    output logic                m_valid,
    input  logic                m_ready,
    output dvf_pkg::dvf_out_t    m_data
);
    import dvf_pkg::*;

    logic [VALUE_W-1:0] mem [TABLE_DEPTH];

    dvf_in_t            item_reg;
    logic [VALUE_W-1:0] rd_data_reg;
    logic [CNT_W-1:0]   pend_idx_reg;
    logic               pend_reg;
    logic [CNT_W-1:0]   idx_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               out_valid_reg;
    dvf_out_t           out_reg;
    dvf_out_t           out_next;
    logic               full;
    logic               append;

    assign full   = (count_reg == CNT_W'(TABLE_DEPTH));
    assign append = !status.match && !full;

    assign status.match    = pend_reg && (rd_data_reg == $unsigned(item_reg.value));
    assign status.more     = (idx_reg < count_reg);
    assign status.out_free = !out_valid_reg || m_ready;

    always_comb begin
        out_next.is_new    = !status.match;
        out_next.value_out = item_reg.value;
        out_next.overflow  = !status.match && full;
        out_next.set_done  = item_reg.last_of_set;
        if (status.match) begin
            out_next.slot = SLOT_W'(pend_idx_reg);
        end else if (full) begin
            out_next.slot = '0;
        end else begin
            out_next.slot = SLOT_W'(count_reg);
        end

        count_next = count_reg;
        if (append) begin
            count_next = count_reg + CNT_W'(1);
        end
        if (item_reg.last_of_set) begin
            count_next = '0;
        end
    end

    // Table memory: one read port for the search, one write port for appends.
    always_ff @(posedge aclk) begin
        if (cmd.step) begin
            rd_data_reg <= mem[idx_reg[ADDR_W-1:0]];
        end
        if (cmd.finish && append) begin
            mem[count_reg[ADDR_W-1:0]] <= $unsigned(item_reg.value);
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            item_reg <= s_data;
        end
        if (cmd.step) begin
            pend_idx_reg <= idx_reg;
        end
        if (cmd.finish) begin
            out_reg <= out_next;
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg      <= 1'b0;
            idx_reg       <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.load) begin
                pend_reg <= 1'b0;
                idx_reg  <= '0;
            end else if (cmd.step) begin
                pend_reg <= 1'b1;
                idx_reg  <= idx_reg + CNT_W'(1);
            end
            if (cmd.finish) begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(TABLE_DEPTH))
        else $error("distinct count exceeds table depth");

    a_step_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.step |-> status.more)
        else $error("search step past the last stored entry");

    a_finish_decided: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |-> (status.match || !status.more) && status.out_free)
        else $error("result finished before the search was decided");

    a_finish_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |=> m_valid)
        else $error("finished result not presented");

endmodule

// ===== hw/rtl/distinct_value_filter.sv =====
// Top level of the distinct value filter: controller plus datapath.
//
// Usage: feed signed 32-bit values on the s_ channel (valid/ready); each
// accepted transaction yields exactly one result transaction on the m_ channel.
// The result reports whether the value is new to the current set, the table
// slot where it was stored or found, overflow when a new value arrived with the
// table full (slot is then 0), and set_done echoing last_of_set. After the
// transaction marked last_of_set the distinct count clears and a new set begins.
//
// Search: the table is searched linearly, one table memory read per cycle,
// compared in the following cycle. A new value is decided once every stored
// entry has been read; a repeat is decided when its slot is read and matches.
// Items are handled one at a time; s_ready is high only between items.
//
// Reset (aresetn, synchronous, active low) empties the table count and drops
// any pending result; table contents are not cleared, as only entries below
// the count are ever read. When the receiver stalls, the result waits in the
// output register and the next transaction may still be accepted and searched;
// it finishes once the previous result has been taken.
module distinct_value_filter (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  dvf_pkg::dvf_in_t  s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output dvf_pkg::dvf_out_t m_data
);
    import dvf_pkg::*;

    dvf_cmd_t    cmd;
    dvf_status_t status;

    // Sequence load, search and finish.
    dvf_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // Hold the item, walk the table and drive the result register.
    dvf_datapath u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .status  (status),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

// ===== tb/dvf_checker.sv =====
// Scoreboard for the distinct value filter: predicts each result and compares it.
`timescale 1ns / 100ps

module dvf_checker (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic              s_ready,
    input  dvf_pkg::dvf_in_t  s_data,
    input  logic              m_valid,
    input  logic              m_ready,
    input  dvf_pkg::dvf_out_t m_data,
    output int                mismatch_count,
    output int                results_pending
);
    import dvf_pkg::*;

    localparam int PRINT_CAP = 60;

    logic [VALUE_W-1:0] seen_values [TABLE_DEPTH];
    int                 seen_count = 0;
    dvf_out_t           expected_results [$];
    int                 errors = 0;

    // Search the distinct table, append on a miss, clear the count on set end.
    function automatic dvf_out_t dedup_result(dvf_in_t item);
        dvf_out_t res;
        int       hit;
        hit = -1;
        for (int k = 0; k < seen_count; k++) begin
            if (hit < 0 && seen_values[k] == item.value) begin
                hit = k;
            end
        end
        res           = '0;
        res.value_out = item.value;
        res.set_done  = item.last_of_set;
        if (hit >= 0) begin
            res.slot = SLOT_W'(hit);
        end else begin
            res.is_new = 1'b1;
            if (seen_count < TABLE_DEPTH) begin
                seen_values[seen_count] = item.value;
                res.slot                = SLOT_W'(seen_count);
                seen_count++;
            end else begin
                res.overflow = 1'b1;
            end
        end
        if (item.last_of_set) begin
            seen_count = 0;
        end
        return res;
    endfunction

    task automatic report_mismatch(string msg);
        if (errors < PRINT_CAP) begin
            $display("[%0t] MISMATCH %s", $time, msg);
        end
        errors++;
    endtask

    task automatic check_field(string field, logic [VALUE_W-1:0] got, logic [VALUE_W-1:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s: got %h, want %h", field, got, want));
        end
    endtask

    always @(posedge aclk) begin
        dvf_out_t want;
        if (!aresetn) begin
            seen_count = 0;
            expected_results.delete();
        end else begin
            // Retire the oldest expectation before adding a new one.
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch($sformatf("unexpected result transaction %h", m_data));
                end else begin
                    want = expected_results.pop_front();
                    check_field("is_new", VALUE_W'(m_data.is_new), VALUE_W'(want.is_new));
                    check_field("value_out", m_data.value_out, want.value_out);
                    check_field("slot", VALUE_W'(m_data.slot), VALUE_W'(want.slot));
                    check_field("overflow", VALUE_W'(m_data.overflow),
                                VALUE_W'(want.overflow));
                    check_field("set_done", VALUE_W'(m_data.set_done),
                                VALUE_W'(want.set_done));
                end
            end
            if (s_valid && s_ready) begin
                expected_results.push_back(dedup_result(s_data));
            end
        end
        mismatch_count  <= errors;
        results_pending <= expected_results.size();
    end

endmodule

// ===== tb/tb_top.sv =====
// Testbench top for the distinct value filter: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb_top;
    import dvf_pkg::*;

    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 4;
    localparam int RANDOM_ITEMS = 1850;
    localparam int LONG_STALL   = 3000;
    localparam int STALL_AT     = 300;
    localparam int DRAIN_TAIL   = TABLE_DEPTH + 12;
    // Allow several times the slowest correct run, long stall included, before
    // calling the run hung.
    localparam int CYCLE_LIMIT  = 1_500_000;
    localparam int FULL_SET_GAP = 25;
    localparam logic [31:0] HASH_STEP = 32'h9E37_79B9;

    localparam logic signed [VALUE_W-1:0] MOST_NEGATIVE = {1'b1, {(VALUE_W-1){1'b0}}};
    localparam logic signed [VALUE_W-1:0] MOST_POSITIVE = {1'b0, {(VALUE_W-1){1'b1}}};
    localparam logic signed [VALUE_W-1:0] ALL_ONES      = '1;
    localparam logic signed [VALUE_W-1:0] ALT_LOW       = 32'h5555_5555;
    localparam logic signed [VALUE_W-1:0] ALT_HIGH      = 32'hAAAA_AAAA;

    logic     aclk    = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    dvf_in_t  s_data  = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    dvf_out_t m_data;

    int   mismatch_count;
    int   results_pending;
    int   items_sent  = 0;
    int   cycle_count = 0;
    logic draining    = 1'b0;

    distinct_value_filter DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    dvf_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data          (s_data),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_data          (m_data),
        .mismatch_count  (mismatch_count),
        .results_pending (results_pending)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // Watchdog: stop a hung run and call it a failure.
    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("Verification failed");
        $finish;
    end

    // Mix of extremes, tiny values that collide often, and fully random words.
    function automatic logic signed [VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 5))
            0: return MOST_NEGATIVE;
            1: return MOST_POSITIVE;
            2: return $urandom_range(0, 8) - 32'd4;
            default: return $urandom;
        endcase
    endfunction

    // Offer one input transaction and hold it until the block takes it.
    // Idle gaps come in stretches: two out of every three blocks of 80 items
    // draw a random gap, the third runs back to back.
    task automatic send_item(logic signed [VALUE_W-1:0] v, logic last);
        int gap;
        gap = ((items_sent / 80) % 3 != 0) ? $urandom_range(0, 19) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= '{value: v, last_of_set: last};
        do @(posedge aclk); while (!s_ready);
        items_sent++;
    endtask

    // Drop valid and hold until every outstanding result has come back.
    task automatic drain();
        draining = 1'b1;
        s_valid <= 1'b0;
        do @(posedge aclk); while (results_pending != 0);
        draining = 1'b0;
    endtask

    // Result side: random backpressure per transaction, with stretches of
    // none, and one long hold-off while the sender keeps offering, so the
    // block fills and stalls its input.
    initial begin : result_sink
        int   wait_cycles;
        int   taken;
        logic long_stall_done;
        taken           = 0;
        long_stall_done = 1'b0;
        forever begin
            if (taken >= STALL_AT && !long_stall_done && !draining) begin
                long_stall_done = 1'b1;
                m_ready <= 1'b0;
                repeat (LONG_STALL) @(posedge aclk);
            end
            wait_cycles = ((taken / 70) % 3 != 1) ? $urandom_range(0, 19) : 0;
            if (wait_cycles > 0) begin
                m_ready <= 1'b0;
                repeat (wait_cycles) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            taken++;
        end
    end

    initial begin : stimulus
        logic signed [VALUE_W-1:0] pool [16];
        logic [31:0]               base;
        int                        pool_n;
        int                        len;
        int                        span;
        int                        set_idx;

        // Hold reset, then release it on a clock edge.
        aresetn <= 1'b0;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: extremes and repeats within one set.
        send_item(MOST_NEGATIVE, 1'b0);
        send_item(MOST_POSITIVE, 1'b0);
        send_item('0, 1'b0);
        send_item(ALL_ONES, 1'b0);
        send_item(MOST_NEGATIVE, 1'b0);   // repeat at the first slot
        send_item(ALL_ONES, 1'b0);        // repeat further in
        send_item(32'sd1, 1'b0);
        send_item(ALT_LOW, 1'b0);
        send_item(ALT_HIGH, 1'b0);
        send_item('0, 1'b1);              // repeat that also ends the set
        // Values seen in an earlier set are new again.
        send_item('0, 1'b1);              // one-item set
        send_item(MOST_POSITIVE, 1'b1);
        send_item(32'sd7, 1'b0);
        send_item(32'sd7, 1'b0);
        send_item(32'sd7, 1'b1);
        drain();

        // Random sets until the item budget is spent.
        set_idx = 0;
        while (items_sent < RANDOM_ITEMS) begin
            set_idx++;
            if (set_idx % FULL_SET_GAP == FULL_SET_GAP / 2) begin
                // Fill the table to the brim or past it: distinct values first
                // (the xor with an odd multiple keeps them distinct), then
                // repeats and dropped values mixed until the set ends.
                span = TABLE_DEPTH + $urandom_range(0, 8);
                base = $urandom;
                for (int i = 0; i < span; i++) begin
                    send_item(base ^ (32'(i) * HASH_STEP), 1'b0);
                end
                len = $urandom_range(10, 40);
                for (int i = 0; i < len; i++) begin
                    send_item(base ^ (32'($urandom_range(0, span - 1)) * HASH_STEP),
                              i == len - 1);
                end
                drain();
            end else if ($urandom_range(0, 9) == 0) begin
                // Noise: random words, set end marked at random.
                len = $urandom_range(1, 10);
                for (int i = 0; i < len; i++) begin
                    send_item($urandom, 1'($urandom_range(0, 1)));
                end
            end else begin
                // Ordinary set drawn from a small pool so repeats are common.
                pool_n = $urandom_range(1, 12);
                for (int i = 0; i < pool_n; i++) begin
                    pool[i] = pick_value();
                end
                len = $urandom_range(1, 24);
                for (int i = 0; i < len; i++) begin
                    send_item(pool[$urandom_range(0, pool_n - 1)], i == len - 1);
                end
            end
        end

        // Let every result come back, then watch a while for stray ones.
        drain();
        repeat (DRAIN_TAIL) @(posedge aclk);

        if (mismatch_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
